FILE: rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the time window thermostat switch.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int TIMER_COUNT  = 8;
   localparam int SENSOR_COUNT = 8;
   localparam int TIDX_W       = $clog2(TIMER_COUNT);
   localparam int SIDX_W       = $clog2(SENSOR_COUNT);

   localparam logic [10:0] DAY_MINUTES   = 11'd1440;
   localparam logic [7:0]  SETPOINT_RST  = 8'sd20;
   localparam logic [10:0] BOOST_RST     = 11'd60;

   typedef enum logic [2:0] {
      MODE_OFF   = 3'd0,
      MODE_ON    = 3'd1,
      MODE_AUTO  = 3'd2,
      MODE_BOOST = 3'd3,
      MODE_ADV   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      OP_EVAL   = 2'd0,
      OP_MODE   = 2'd1,
      OP_TIMER  = 2'd2,
      OP_SENSOR = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_MASK  = 1'b0,
      CSR_BOOST = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SENSE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan_start;
      logic scan_step;
      logic sense;
      logic out_valid;
   } cmd_type;

   typedef struct packed {
      logic is_eval_auto;
      logic scan_hit;
      logic scan_last;
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [10:0] now_minute;
      logic        time_synced;
      logic [2:0]  mode_request;
      logic [2:0]  timer_index;
      logic [10:0] on_minute;
      logic [10:0] off_minute;
      logic signed [7:0] setpoint;
      logic [6:0]  hysteresis;
      logic        less_than;
      logic [3:0]  sensor_select;
      logic signed [15:0] sensor_value;
   } req_type;

   typedef struct packed {
      logic       output_on;
      logic [2:0] mode;
      logic       settings_changed;
   } rsp_type;

endpackage

FILE: rtl/core/tts_if.sv
// ----------------------------------------------------------------------------
// tts_req_if / tts_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tts_req_if;
   logic             valid;
   logic             ready;
   tts_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tts_rsp_if;
   logic             valid;
   logic             ready;
   tts_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: load request, execute, scan windows, sensor check, deliver.
// ----------------------------------------------------------------------------
module tts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  tts_pkg::status_type status,
   output tts_pkg::cmd_type    cmd
);

   tts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tts_pkg::ST_IDLE: begin
            if (req_valid) state_in = tts_pkg::ST_EXEC;
         end
         tts_pkg::ST_EXEC: begin
            state_in = status.is_eval_auto ? tts_pkg::ST_SCAN : tts_pkg::ST_DONE;
         end
         tts_pkg::ST_SCAN: begin
            if (status.scan_hit) state_in = tts_pkg::ST_SENSE;
            else if (status.scan_last) state_in = tts_pkg::ST_DONE;
         end
         tts_pkg::ST_SENSE: state_in = tts_pkg::ST_DONE;
         tts_pkg::ST_DONE: begin
            if (out_free) state_in = tts_pkg::ST_IDLE;
         end
         default: state_in = tts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tts_pkg::ST_EXEC: begin
            cmd.exec       = 1'b1;
            cmd.scan_start = status.is_eval_auto;
         end
         tts_pkg::ST_SCAN:  cmd.scan_step = !status.scan_hit;
         tts_pkg::ST_SENSE: cmd.sense = 1'b1;
         tts_pkg::ST_DONE:  cmd.out_valid = out_free;
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/tts_dp.sv
// ----------------------------------------------------------------------------
// tts_dp
// Datapath: mode state, timer table, sensor store and result latch.
// ----------------------------------------------------------------------------
module tts_dp (
   input  logic                clock,
   input  logic                reset,
   input  tts_pkg::cmd_type    cmd,
   output tts_pkg::status_type status,
   input  tts_pkg::req_type    req,
   input  logic [7:0]          mask,
   input  logic [10:0]         boost_len,
   output tts_pkg::rsp_type    rsp
);

   localparam int TC = tts_pkg::TIMER_COUNT;
   localparam int SC = tts_pkg::SENSOR_COUNT;
   localparam int TW = tts_pkg::TIDX_W;
   localparam int SW = tts_pkg::SIDX_W;

   tts_pkg::req_type r_ff;
   logic [10:0] now_w;
   logic [2:0]  mode_ff, mode_in, prev_ff, prev_in;
   logic        out_ff, out_in, chg_ff, chg_in;
   logic [10:0] on_ff [TC];
   logic [10:0] off_ff [TC];
   logic signed [7:0] sp_ff [TC];
   logic [6:0]  hy_ff [TC];
   logic        less_ff [TC];
   logic        hs_ff [TC];
   logic [SW-1:0] sn_ff [TC];
   logic signed [15:0] sv_ff [SC];
   logic        ls_ff [SC];
   logic [TW-1:0] idx_ff;

   logic [10:0] won, woff;
   logic        win_hit, win0;
   logic [11:0] bsum;
   logic [10:0] boff;
   logic [TW-1:0] ti;
   logic        ti_ok, sel_ok;
   logic [SW-1:0] si;
   logic signed [8:0] lo, hi;
   logic signed [15:0] sv;
   logic        sact, dig;

   assign now_w = (r_ff.now_minute >= tts_pkg::DAY_MINUTES) ?
                  r_ff.now_minute - tts_pkg::DAY_MINUTES : r_ff.now_minute;

   function automatic logic in_win(logic [10:0] a, logic [10:0] b, logic [10:0] n);
      if (a == b) return 1'b0;
      if (b > a) return (n >= a) && (n < b);
      return !((n >= b) && (n < a));
   endfunction

   assign won     = on_ff[idx_ff];
   assign woff    = off_ff[idx_ff];
   assign win_hit = in_win(won, woff, now_w);
   assign win0    = in_win(on_ff[0], off_ff[0], now_w);

   assign status.is_eval_auto = (r_ff.op == tts_pkg::OP_EVAL) && r_ff.time_synced &&
                                (mode_ff == tts_pkg::MODE_AUTO);
   assign status.scan_hit  = win_hit;
   assign status.scan_last = (32'(idx_ff) == TC - 1);

   // boost length spans the full 11-bit range, so the sum may pass two days
   assign bsum = {1'b0, now_w} + {1'b0, boost_len};
   assign boff = (bsum >= {tts_pkg::DAY_MINUTES, 1'b0}) ?
                 11'(bsum - {tts_pkg::DAY_MINUTES, 1'b0}) :
                 (bsum >= {1'b0, tts_pkg::DAY_MINUTES}) ?
                 11'(bsum - {1'b0, tts_pkg::DAY_MINUTES}) : bsum[10:0];

   assign ti     = r_ff.timer_index[TW-1:0];
   assign ti_ok  = (32'(r_ff.timer_index) < TC);
   assign sel_ok = (32'(r_ff.sensor_select) < SC);
   assign si     = r_ff.sensor_select[SW-1:0];

   // sensor decision for the window found by the scan
   assign sv  = sv_ff[sn_ff[idx_ff]];
   assign dig = (32'(sn_ff[idx_ff]) < 8) && mask[3'(sn_ff[idx_ff])];
   assign lo  = 9'(sp_ff[idx_ff]) - 9'(signed'({1'b0, hy_ff[idx_ff]}));
   assign hi  = 9'(sp_ff[idx_ff]) + 9'(signed'({1'b0, hy_ff[idx_ff]}));
   always_comb begin
      if (!hs_ff[idx_ff]) sact = 1'b1;
      else if (dig) sact = (less_ff[idx_ff] == (sv == 16'sd0));
      else if (sv >= 16'(lo) && sv <= 16'(hi)) sact = ls_ff[sn_ff[idx_ff]];
      else sact = ((sv < 16'(lo)) == less_ff[idx_ff]);
   end

   always_comb begin
      mode_in = mode_ff;
      prev_in = prev_ff;
      out_in  = out_ff;
      chg_in  = chg_ff;
      if (cmd.load) chg_in = 1'b0;
      if (cmd.exec) begin
         unique case (r_ff.op)
            tts_pkg::OP_EVAL: begin
               if (mode_ff == tts_pkg::MODE_OFF || !r_ff.time_synced) out_in = 1'b0;
               else if (mode_ff == tts_pkg::MODE_ON) out_in = 1'b1;
               else if (mode_ff == tts_pkg::MODE_BOOST || mode_ff == tts_pkg::MODE_ADV) begin
                  out_in = win0;
                  if (!win0) begin
                     mode_in = prev_ff;
                     chg_in  = 1'b1;
                  end
               end else out_in = 1'b0;
            end
            tts_pkg::OP_MODE: begin
               priority if (r_ff.mode_request == tts_pkg::MODE_OFF ||
                            r_ff.mode_request == tts_pkg::MODE_ON ||
                            r_ff.mode_request == tts_pkg::MODE_AUTO) begin
                  if (mode_ff != r_ff.mode_request) begin
                     mode_in = r_ff.mode_request;
                     chg_in  = 1'b1;
                  end
               end else if (r_ff.mode_request == tts_pkg::MODE_BOOST) begin
                  if (mode_ff != tts_pkg::MODE_BOOST && mode_ff != tts_pkg::MODE_ADV)
                     prev_in = mode_ff;
                  mode_in = tts_pkg::MODE_BOOST;
                  chg_in  = 1'b1;
               end else if (r_ff.mode_request == tts_pkg::MODE_ADV) begin
                  if (mode_ff != tts_pkg::MODE_ADV && on_ff[1] != off_ff[1]) begin
                     if (mode_ff != tts_pkg::MODE_BOOST) prev_in = mode_ff;
                     mode_in = tts_pkg::MODE_ADV;
                     chg_in  = 1'b1;
                  end
               end else begin
               end
            end
            tts_pkg::OP_TIMER: begin
               if (ti_ok) begin
                  if (r_ff.on_minute != on_ff[ti] || r_ff.off_minute != off_ff[ti] ||
                      (r_ff.setpoint > -8'sd127 && r_ff.setpoint < 8'sd127 &&
                       r_ff.setpoint != sp_ff[ti]) ||
                      r_ff.less_than != less_ff[ti] || r_ff.hysteresis != hy_ff[ti] ||
                      (sel_ok && (!hs_ff[ti] || si != sn_ff[ti])))
                     chg_in = 1'b1;
               end
            end
            tts_pkg::OP_SENSOR: ;
            default: ;
         endcase
      end
      if (cmd.exec && status.is_eval_auto) out_in = 1'b0;
      if (cmd.sense) out_in = sact;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tts_pkg::MODE_OFF;
         prev_ff <= tts_pkg::MODE_OFF;
         out_ff  <= 1'b0;
         chg_ff  <= 1'b0;
         for (int i = 0; i < TC; i++) begin
            on_ff[i]   <= '0;
            off_ff[i]  <= '0;
            sp_ff[i]   <= tts_pkg::SETPOINT_RST;
            hy_ff[i]   <= '0;
            less_ff[i] <= 1'b1;
            hs_ff[i]   <= 1'b0;
            sn_ff[i]   <= '0;
         end
         for (int i = 0; i < SC; i++) begin
            sv_ff[i] <= '0;
            ls_ff[i] <= 1'b0;
         end
      end else begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         out_ff  <= out_in;
         chg_ff  <= chg_in;
         if (cmd.exec) begin
            unique case (r_ff.op)
               tts_pkg::OP_EVAL: begin
                  if ((mode_ff == tts_pkg::MODE_BOOST || mode_ff == tts_pkg::MODE_ADV) &&
                      r_ff.time_synced && !win0)
                     off_ff[0] <= on_ff[0];
               end
               tts_pkg::OP_MODE: begin
                  if ((r_ff.mode_request == tts_pkg::MODE_OFF ||
                       r_ff.mode_request == tts_pkg::MODE_ON ||
                       r_ff.mode_request == tts_pkg::MODE_AUTO) &&
                      mode_ff != r_ff.mode_request) begin
                     on_ff[0]  <= '0;
                     off_ff[0] <= '0;
                  end else if (r_ff.mode_request == tts_pkg::MODE_BOOST) begin
                     on_ff[0]  <= now_w;
                     off_ff[0] <= boff;
                  end else if (r_ff.mode_request == tts_pkg::MODE_ADV &&
                               mode_ff != tts_pkg::MODE_ADV && on_ff[1] != off_ff[1]) begin
                     on_ff[0]  <= now_w;
                     off_ff[0] <= off_ff[1];
                  end
               end
               tts_pkg::OP_TIMER: begin
                  if (ti_ok) begin
                     on_ff[ti]   <= r_ff.on_minute;
                     off_ff[ti]  <= r_ff.off_minute;
                     hy_ff[ti]   <= r_ff.hysteresis;
                     less_ff[ti] <= r_ff.less_than;
                     if (r_ff.setpoint > -8'sd127 && r_ff.setpoint < 8'sd127)
                        sp_ff[ti] <= r_ff.setpoint;
                     if (sel_ok) begin
                        hs_ff[ti] <= 1'b1;
                        sn_ff[ti] <= si;
                     end
                  end
               end
               tts_pkg::OP_SENSOR: begin
                  if (sel_ok) sv_ff[si] <= r_ff.sensor_value;
               end
               default: ;
            endcase
         end
         if (cmd.sense && hs_ff[idx_ff] && !dig &&
             !(sv >= 16'(lo) && sv <= 16'(hi)))
            ls_ff[sn_ff[idx_ff]] <= sact;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (cmd.scan_start) idx_ff <= TW'(1);
      else if (cmd.scan_step && !status.scan_last) idx_ff <= idx_ff + TW'(1);
   end

   assign rsp.output_on        = out_ff;
   assign rsp.mode             = mode_ff;
   assign rsp.settings_changed = chg_ff;

endmodule

FILE: rtl/core/time_window_thermostat_switch.sv
// ----------------------------------------------------------------------------
// time_window_thermostat_switch
// Mode, timer window and sensor controller for one relay output.
// ----------------------------------------------------------------------------
// One request at a time: a request goes through execute to a result register,
// and an AUTO evaluate also scans the window table one entry a cycle and may
// check a sensor. A new request is taken once the previous
// result has moved into the output register.
module time_window_thermostat_switch (
   input  logic        clock,
   input  logic        reset,
   tts_req_if.sink     req,
   tts_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tts_pkg::cmd_type    cmd;
   tts_pkg::status_type status;
   tts_pkg::rsp_type    res, rsp_ff;
   logic        vld_ff;
   logic [7:0]  mask_ff;
   logic [10:0] boost_ff;
   logic        out_free;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         boost_ff <= tts_pkg::BOOST_RST;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == tts_pkg::CSR_MASK) mask_ff <= csr_pwdata[7:0];
         else boost_ff <= csr_pwdata[10:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == tts_pkg::CSR_MASK) csr_prdata[7:0] = mask_ff;
      else csr_prdata[10:0] = boost_ff;
   end

   assign out_free = !vld_ff || rsp.ready;

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   tts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req.payload),
      .mask      (mask_ff),
      .boost_len (boost_ff),
      .rsp       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.out_valid) begin
         vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_valid) rsp_ff <= res;
   end

   assign rsp.valid   = vld_ff;
   assign rsp.payload = rsp_ff;

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.exec, cmd.scan_step, cmd.sense, cmd.out_valid}))
      else $error("multiple sequencer commands");
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req.ready)
      else $error("load without ready");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result dropped");
`endif

endmodule

FILE: tb/sv/time_window_thermostat_switch_tb.sv
// ----------------------------------------------------------------------------
// time_window_thermostat_switch_tb
// Drives mode, timer, sensor and evaluate requests into the switch with random
// bursts and stalls, predicts each result in a local model and checks it.
// ----------------------------------------------------------------------------
module time_window_thermostat_switch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [10:0]       on_m;
      logic [10:0]       off_m;
      logic signed [7:0] sp;
      logic [6:0]        hyst;
      logic              less;
      logic              linked;
      logic [2:0]        sensor;
   } window_type;

   logic clock = 0;
   logic reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tts_req_if req_if();
   tts_rsp_if rsp_if();

   time_window_thermostat_switch DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // switch state mirror
   logic [7:0]         sensor_mask;
   logic [10:0]        boost_len;
   tts_pkg::mode_type  cur_mode, prev_mode;
   window_type         windows[tts_pkg::TIMER_COUNT];
   logic signed [15:0] readings[tts_pkg::SENSOR_COUNT];
   logic               sensor_state[tts_pkg::SENSOR_COUNT];
   logic               relay;

   tts_pkg::req_type pending_reqs[$];
   tts_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      hold_off = 0;
   int      burst_left = 0, gap_left = 0;
   bit      sender_pause = 0;

   function automatic logic in_window(int t, logic [10:0] now);
      if (windows[t].on_m == windows[t].off_m) return 0;
      if (windows[t].off_m > windows[t].on_m)
         return now >= windows[t].on_m && now < windows[t].off_m;
      return !(now >= windows[t].off_m && now < windows[t].on_m);
   endfunction

   function automatic logic sensor_gate(int t);
      int s, v, lo, hi;
      logic st;
      if (!windows[t].linked) return 1;
      s = windows[t].sensor;
      v = readings[s];
      if (sensor_mask[s]) return windows[t].less == (v == 0);
      lo = int'(windows[t].sp) - int'(windows[t].hyst);
      hi = int'(windows[t].sp) + int'(windows[t].hyst);
      if (v >= lo && v <= hi) return sensor_state[s];
      st = ((v < lo) == windows[t].less);
      sensor_state[s] = st;
      return st;
   endfunction

   function automatic void predict_switch(tts_pkg::req_type r);
      logic [10:0]       now;
      logic              chg;
      logic              hit;
      logic              boosting;
      tts_pkg::mode_type m;
      tts_pkg::rsp_type  e;
      now = r.now_minute % tts_pkg::DAY_MINUTES;
      chg = 0;
      boosting = cur_mode == tts_pkg::MODE_BOOST || cur_mode == tts_pkg::MODE_ADV;
      case (tts_pkg::op_type'(r.op))
         tts_pkg::OP_EVAL: begin
            if (cur_mode == tts_pkg::MODE_OFF || !r.time_synced) relay = 0;
            else if (cur_mode == tts_pkg::MODE_ON) relay = 1;
            else if (boosting) begin
               if (in_window(0, now)) relay = 1;
               else begin
                  cur_mode = prev_mode;
                  windows[0].off_m = windows[0].on_m;
                  chg = 1;
                  relay = 0;
               end
            end else begin
               relay = 0;
               hit = 0;
               for (int t = 1; t < tts_pkg::TIMER_COUNT; t++)
                  if (!hit && in_window(t, now)) begin
                     hit = 1;
                     relay = sensor_gate(t);
                  end
            end
         end
         tts_pkg::OP_MODE: begin
            m = tts_pkg::mode_type'(r.mode_request);
            if (r.mode_request <= tts_pkg::MODE_AUTO) begin
               if (cur_mode != m) begin
                  cur_mode = m;
                  windows[0].on_m = 0;
                  windows[0].off_m = 0;
                  chg = 1;
               end
            end else if (r.mode_request == tts_pkg::MODE_BOOST) begin
               if (!boosting) prev_mode = cur_mode;
               cur_mode = tts_pkg::MODE_BOOST;
               windows[0].on_m = now;
               windows[0].off_m = (32'(now) + boost_len) % tts_pkg::DAY_MINUTES;
               chg = 1;
            end else if (r.mode_request == tts_pkg::MODE_ADV) begin
               if (cur_mode != tts_pkg::MODE_ADV && windows[1].on_m != windows[1].off_m) begin
                  if (!boosting) prev_mode = cur_mode;
                  cur_mode = tts_pkg::MODE_ADV;
                  windows[0].on_m = now;
                  windows[0].off_m = windows[1].off_m;
                  chg = 1;
               end
            end
         end
         tts_pkg::OP_TIMER: begin
            if (r.timer_index < tts_pkg::TIMER_COUNT) begin
               window_type w;
               w = windows[r.timer_index];
               if (r.on_minute != w.on_m) begin w.on_m = r.on_minute; chg = 1; end
               if (r.off_minute != w.off_m) begin w.off_m = r.off_minute; chg = 1; end
               if (r.setpoint > -127 && r.setpoint < 127 && r.setpoint != w.sp) begin
                  w.sp = r.setpoint;
                  chg = 1;
               end
               if (r.less_than != w.less) begin w.less = r.less_than; chg = 1; end
               if (r.hysteresis != w.hyst) begin w.hyst = r.hysteresis; chg = 1; end
               if (r.sensor_select < tts_pkg::SENSOR_COUNT &&
                   (!w.linked || r.sensor_select[2:0] != w.sensor)) begin
                  w.linked = 1;
                  w.sensor = r.sensor_select[2:0];
                  chg = 1;
               end
               windows[r.timer_index] = w;
            end
         end
         default: begin
            if (r.sensor_select < tts_pkg::SENSOR_COUNT)
               readings[r.sensor_select] = r.sensor_value;
         end
      endcase
      e.output_on = relay;
      e.mode = cur_mode;
      e.settings_changed = chg;
      expected_rsps.push_back(e);
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_if.valid <= 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_switch(req_if.payload);
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 0;
            end else if (pending_reqs.size() > 0 && !sender_pause) begin
               req_if.payload <= pending_reqs.pop_front();
               req_if.valid <= 1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected result: actual %p", $time, rsp_if.payload);
               errors++;
            end else begin
               tts_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.output_on !== rsp_if.payload.output_on)
                  $display("%0t output_on: expected %0b actual %0b", $time,
                           e.output_on, rsp_if.payload.output_on);
               if (e.mode !== rsp_if.payload.mode)
                  $display("%0t mode: expected %0d actual %0d", $time,
                           e.mode, rsp_if.payload.mode);
               if (e.settings_changed !== rsp_if.payload.settings_changed)
                  $display("%0t settings_changed: expected %0b actual %0b", $time,
                           e.settings_changed, rsp_if.payload.settings_changed);
               if (e !== rsp_if.payload) errors++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_if.ready <= 0;
         end else if ((cycles / 64) % 4 == 0) begin
            rsp_if.ready <= 1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 600000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(tts_pkg::csr_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 3'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (idx == tts_pkg::CSR_MASK) sensor_mask = value[7:0];
      else boost_len = value[10:0];
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic tts_pkg::req_type rand_req(tts_pkg::op_type op);
      tts_pkg::req_type r;
      r = tts_pkg::req_type'({$urandom, $urandom, $urandom});
      r.op = op;
      r.now_minute = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
      r.time_synced = ($urandom_range(0, 7) != 0);
      r.mode_request = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      r.timer_index = 3'($urandom);
      r.on_minute = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
      r.off_minute = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
      if ($urandom_range(0, 3) == 0) r.off_minute = r.on_minute;
      r.sensor_select = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
      r.sensor_value = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                   : 16'($signed($urandom_range(0, 80)) - 40);
      if ($urandom_range(0, 5) == 0) r.sensor_value = 0;
      r.setpoint = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60) - 30);
      r.hysteresis = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
      return r;
   endfunction

   function automatic void add_req(tts_pkg::op_type op, int a = -1);
      tts_pkg::req_type r;
      r = rand_req(op);
      if (op == tts_pkg::OP_MODE && a >= 0) r.mode_request = 3'(a);
      if (op == tts_pkg::OP_TIMER && a >= 0) r.timer_index = 3'(a);
      pending_reqs.push_back(r);
   endfunction

   function automatic void add_phase(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) add_req(tts_pkg::OP_EVAL);
         else if (pick < 58) add_req(tts_pkg::OP_MODE);
         else if (pick < 78) add_req(tts_pkg::OP_TIMER);
         else add_req(tts_pkg::OP_SENSOR);
      end
   endfunction

   initial begin
      tts_pkg::req_type r;
      req_if.valid = 0;
      req_if.payload = '0;
      rsp_if.ready = 0;
      sensor_mask = 0;
      boost_len = 60;
      cur_mode = tts_pkg::MODE_OFF;
      prev_mode = tts_pkg::MODE_OFF;
      relay = 0;
      for (int i = 0; i < tts_pkg::TIMER_COUNT; i++)
         windows[i] = '{on_m: 0, off_m: 0, sp: 20, hyst: 0, less: 1, linked: 0, sensor: 0};
      for (int i = 0; i < tts_pkg::SENSOR_COUNT; i++) begin
         readings[i] = 0;
         sensor_state[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      csr_write(tts_pkg::CSR_MASK, 32'h0000_00A5);
      csr_write(tts_pkg::CSR_BOOST, 32'd1439);

      // directed: extremes, every mode, wrap windows, setpoint limits
      r = rand_req(tts_pkg::OP_EVAL); r.time_synced = 0; r.now_minute = 11'h7FF;
      pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_TIMER); r.timer_index = 1; r.on_minute = 1400; r.off_minute = 60;
      r.setpoint = -128; r.hysteresis = 127; r.sensor_select = 8; pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_TIMER); r.timer_index = 2; r.on_minute = 11'h7FF;
      r.off_minute = 0; r.setpoint = 127; r.sensor_select = 15; pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_TIMER); r.timer_index = 3; r.on_minute = 100; r.off_minute = 200;
      r.setpoint = -126; r.hysteresis = 0; r.sensor_select = 1; pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_SENSOR); r.sensor_select = 1; r.sensor_value = -32768;
      pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_SENSOR); r.sensor_select = 8; r.sensor_value = 32767;
      pending_reqs.push_back(r);
      for (int m = 0; m < 8; m++) begin
         r = rand_req(tts_pkg::OP_MODE); r.mode_request = 3'(m); r.now_minute = 1439;
         pending_reqs.push_back(r);
         r = rand_req(tts_pkg::OP_EVAL); r.time_synced = 1; r.now_minute = 150;
         pending_reqs.push_back(r);
      end
      r = rand_req(tts_pkg::OP_MODE); r.mode_request = tts_pkg::MODE_BOOST;
      pending_reqs.push_back(r);
      r = rand_req(tts_pkg::OP_EVAL); r.time_synced = 1; r.now_minute = 11'd1500;
      pending_reqs.push_back(r);
      drain();

      // receiver held off while the sender keeps offering
      hold_off = 300;
      add_phase(40);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(tts_pkg::CSR_MASK, 32'h0);
               csr_write(tts_pkg::CSR_BOOST, 32'd1);
            end
            1: begin
               csr_write(tts_pkg::CSR_MASK, 32'hFF);
               csr_write(tts_pkg::CSR_BOOST, 32'd60);
            end
            default: begin
               csr_write(tts_pkg::CSR_MASK, $urandom_range(0, 255));
               csr_write(tts_pkg::CSR_BOOST, $urandom_range(1, 1439));
            end
         endcase
         for (int k = 0; k < 5; k++) begin
            add_req(tts_pkg::OP_MODE, tts_pkg::MODE_AUTO);
            for (int j = 1; j < 4; j++) add_req(tts_pkg::OP_TIMER, j);
            add_phase(59);
         end
         if (ph == 3) begin
            while (pending_reqs.size() > 0) @(posedge clock);
            sender_pause = 1;
            while (req_if.valid || expected_rsps.size() > 0) @(posedge clock);
            sender_pause = 0;
         end
         drain();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
